// ===== hdl/tccs_pkg.sv =====
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W    = $clog2(CELL_COUNT);
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
    localparam int COL_W     = $clog2(SCREEN_WIDTH);
    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int STEP_W    = 4;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_DISPATCH  = 3'd1,
        COND_FILL_BUSY = 3'd2,
        COND_COPY_BUSY = 3'd3,
        COND_NO_SCROLL = 3'd4
    } cond_t;

    typedef enum logic [1:0] {
        EMIT_NEVER  = 2'd0,
        EMIT_ALWAYS = 2'd1,
        EMIT_TAKEN  = 2'd2
    } emit_t;

    typedef enum logic [1:0] {
        ADDR_HOLD = 2'd0,
        ADDR_ZERO = 2'd1,
        ADDR_INC  = 2'd2
    } addr_op_t;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_FILL = 2'd1,
        WR_CHAR = 2'd2,
        WR_COPY = 2'd3
    } wr_sel_t;

    typedef enum logic {
        RD_INDEX = 1'b0,
        RD_AHEAD = 1'b1
    } rd_sel_t;

    typedef enum logic [1:0] {
        CUR_HOLD    = 2'd0,
        CUR_ADVANCE = 2'd1,
        CUR_HOME    = 2'd2
    } cur_op_t;

    typedef struct packed {
        logic     take;
        cond_t    cond;
        step_t    target;
        emit_t    emit;
        addr_op_t addr_op;
        wr_sel_t  wr_sel;
        rd_sel_t  rd_sel;
        cur_op_t  cur_op;
        logic     load_fill;
        logic     show_read;
    } ucw_t;

    typedef struct packed {
        addr_op_t addr_op;
        wr_sel_t  wr_sel;
        rd_sel_t  rd_sel;
        cur_op_t  cur_op;
        logic     load_fill;
    } dp_ctrl_t;

    typedef struct packed {
        logic fill_busy;
        logic copy_busy;
        logic scroll;
    } dp_stat_t;

endpackage

// ===== hdl/text_console_cursor_scroll.sv =====
`timescale 1ns / 1ps

// Text console engine with an 80 x 25 screen of 16-bit cells held in one
// block RAM and a cursor. After reset the block blanks every cell, one per
// cycle, and accepts no item during that pass. A clear item blanks every
// cell, one per cycle. A put character that moves the cursor past the last
// row scrolls the screen: one RAM copy per cell for the 1920 cells that move
// up, then 80 blanks for the bottom row. A short microprogram sequences
// every operation over the single-port-pair RAM. A result waits in an
// output register, so the next item can be taken while the previous result
// is still stalled.
module text_console_cursor_scroll (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                blank_attribute_we,
    input  logic [tccs_pkg::ATTR_W-1:0]         blank_attribute,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [tccs_pkg::FUNC_W-1:0]         func,
    input  logic [tccs_pkg::CHAR_W-1:0]         char_code,
    input  logic [tccs_pkg::COLOR_W-1:0]        fg_color,
    input  logic [tccs_pkg::COLOR_W-1:0]        bg_color,
    input  logic [tccs_pkg::INDEX_W-1:0]        cell_index,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [tccs_pkg::CELL_W-1:0]         cell_value,
    output logic [tccs_pkg::ROW_OUT_W-1:0]      cursor_row,
    output logic [tccs_pkg::COL_OUT_W-1:0]      cursor_col
);
    import tccs_pkg::*;

    logic [ATTR_W-1:0]    blank_attr_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic [COLOR_W-1:0]   fg_reg;
    logic [COLOR_W-1:0]   bg_reg;
    logic [INDEX_W-1:0]   index_reg;

    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic [CELL_W-1:0]    cell_value_reg;
    logic [ROW_OUT_W-1:0] cursor_row_reg;
    logic [COL_OUT_W-1:0] cursor_col_reg;

    logic                 accept;
    logic                 out_busy;
    logic                 emit;
    logic                 show_read;
    logic                 index_ok;
    dp_ctrl_t             ctrl;
    dp_stat_t             stat;
    logic [CELL_W-1:0]    cell_data;
    logic [ROW_W-1:0]     row_next;
    logic [COL_W-1:0]     col_next;

    assign accept   = item_valid && !item_stall;
    assign out_busy = result_valid_reg && result_stall;
    assign index_ok = (32'(index_reg) < 32'(CELL_COUNT));

    tccs_useq u_useq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_func  (func),
        .out_busy   (out_busy),
        .stat       (stat),
        .item_stall (item_stall),
        .ctrl       (ctrl),
        .emit       (emit),
        .show_read  (show_read)
    );

    tccs_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .blank_attr (blank_attr_reg),
        .char_code  (char_reg),
        .fg_color   (fg_reg),
        .bg_color   (bg_reg),
        .cell_index (accept ? cell_index : index_reg),
        .stat       (stat),
        .cell_data  (cell_data),
        .row_next   (row_next),
        .col_next   (col_next)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= char_code;
            fg_reg    <= fg_color;
            bg_reg    <= bg_color;
            index_reg <= cell_index;
        end
        if (emit)
        begin
            cell_value_reg <= (show_read && index_ok) ? cell_data : '0;
            cursor_row_reg <= ROW_OUT_W'(row_next);
            cursor_col_reg <= COL_OUT_W'(col_next);
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_attr_reg   <= RESET_ATTR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (blank_attribute_we)
            begin
                blank_attr_reg <= blank_attribute;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign cell_value   = cell_value_reg;
    assign cursor_row   = cursor_row_reg;
    assign cursor_col   = cursor_col_reg;

endmodule

// ===== hdl/tccs_useq.sv =====
`timescale 1ns / 1ps

module tccs_useq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  logic [tccs_pkg::FUNC_W-1:0]        item_func,
    input  logic                               out_busy,
    input  tccs_pkg::dp_stat_t                 stat,
    output logic                               item_stall,
    output tccs_pkg::dp_ctrl_t                 ctrl,
    output logic                               emit,
    output logic                               show_read
);
    import tccs_pkg::*;

    localparam step_t S_RST_FILL  = 4'd0;
    localparam step_t S_WAIT      = 4'd1;
    localparam step_t S_PUT       = 4'd2;
    localparam step_t S_SCR_START = 4'd3;
    localparam step_t S_SCR_COPY  = 4'd4;
    localparam step_t S_FILL      = 4'd5;
    localparam step_t S_EMIT      = 4'd6;
    localparam step_t S_READ      = 4'd7;
    localparam step_t S_CLR_START = 4'd8;

    function automatic ucw_t rom(input step_t s);
        ucw_t w;
        w.take      = 1'b0;
        w.cond      = COND_ALWAYS;
        w.target    = S_WAIT;
        w.emit      = EMIT_NEVER;
        w.addr_op   = ADDR_HOLD;
        w.wr_sel    = WR_NONE;
        w.rd_sel    = RD_INDEX;
        w.cur_op    = CUR_HOLD;
        w.load_fill = 1'b0;
        w.show_read = 1'b0;
        case (s)
            S_RST_FILL:
            begin
                w.wr_sel  = WR_FILL;
                w.addr_op = ADDR_INC;
                w.cond    = COND_FILL_BUSY;
                w.target  = S_RST_FILL;
            end
            S_WAIT:
            begin
                w.take = 1'b1;
                w.cond = COND_DISPATCH;
            end
            S_PUT:
            begin
                w.wr_sel = WR_CHAR;
                w.cur_op = CUR_ADVANCE;
                w.cond   = COND_NO_SCROLL;
                w.target = S_WAIT;
                w.emit   = EMIT_TAKEN;
            end
            S_SCR_START:
            begin
                w.addr_op   = ADDR_ZERO;
                w.rd_sel    = RD_AHEAD;
                w.load_fill = 1'b1;
                w.target    = S_SCR_COPY;
            end
            S_SCR_COPY:
            begin
                w.wr_sel  = WR_COPY;
                w.addr_op = ADDR_INC;
                w.rd_sel  = RD_AHEAD;
                w.cond    = COND_COPY_BUSY;
                w.target  = S_SCR_COPY;
            end
            S_FILL:
            begin
                w.wr_sel  = WR_FILL;
                w.addr_op = ADDR_INC;
                w.cond    = COND_FILL_BUSY;
                w.target  = S_FILL;
            end
            S_EMIT:
            begin
                w.emit = EMIT_ALWAYS;
            end
            S_READ:
            begin
                w.emit      = EMIT_ALWAYS;
                w.show_read = 1'b1;
            end
            S_CLR_START:
            begin
                w.addr_op   = ADDR_ZERO;
                w.load_fill = 1'b1;
                w.cur_op    = CUR_HOME;
                w.target    = S_FILL;
            end
            default:
            begin
                w.target = S_WAIT;
            end
        endcase
        return w;
    endfunction

    step_t upc_reg;
    step_t upc_next;
    ucw_t  cw;
    logic  accept;
    logic  cond_true;
    logic  emit_req;
    logic  hold;
    step_t dispatch_target;

    assign cw         = rom(upc_reg);
    assign accept     = cw.take && item_valid;
    assign item_stall = !cw.take;

    always_comb
    begin
        case (cw.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_DISPATCH:  cond_true = accept;
            COND_FILL_BUSY: cond_true = stat.fill_busy;
            COND_COPY_BUSY: cond_true = stat.copy_busy;
            COND_NO_SCROLL: cond_true = !stat.scroll;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cw.emit)
            EMIT_ALWAYS: emit_req = 1'b1;
            EMIT_TAKEN:  emit_req = cond_true;
            default:     emit_req = 1'b0;
        endcase
    end

    assign hold      = emit_req && out_busy;
    assign emit      = emit_req && !hold;
    assign show_read = cw.show_read;

    always_comb
    begin
        case (func_t'(item_func))
            FUNC_PUT:   dispatch_target = S_PUT;
            FUNC_CLEAR: dispatch_target = S_CLR_START;
            FUNC_READ:  dispatch_target = S_READ;
            default:    dispatch_target = S_EMIT;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            upc_next = upc_reg;
        end
        else if (cw.cond == COND_DISPATCH)
        begin
            upc_next = accept ? dispatch_target : upc_reg;
        end
        else if (cond_true)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = upc_reg + step_t'(1);
        end
    end

    always_comb
    begin
        ctrl.addr_op   = cw.addr_op;
        ctrl.wr_sel    = cw.wr_sel;
        ctrl.rd_sel    = cw.rd_sel;
        ctrl.cur_op    = cw.cur_op;
        ctrl.load_fill = cw.load_fill;
        if (hold)
        begin
            ctrl.addr_op   = ADDR_HOLD;
            ctrl.wr_sel    = WR_NONE;
            ctrl.cur_op    = CUR_HOLD;
            ctrl.load_fill = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_RST_FILL;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== hdl/tccs_dpath.sv =====
`timescale 1ns / 1ps

module tccs_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tccs_pkg::dp_ctrl_t                 ctrl,
    input  logic [tccs_pkg::ATTR_W-1:0]        blank_attr,
    input  logic [tccs_pkg::CHAR_W-1:0]        char_code,
    input  logic [tccs_pkg::COLOR_W-1:0]       fg_color,
    input  logic [tccs_pkg::COLOR_W-1:0]       bg_color,
    input  logic [tccs_pkg::INDEX_W-1:0]       cell_index,
    output tccs_pkg::dp_stat_t                 stat,
    output logic [tccs_pkg::CELL_W-1:0]        cell_data,
    output logic [tccs_pkg::ROW_W-1:0]         row_next,
    output logic [tccs_pkg::COL_W-1:0]         col_next
);
    import tccs_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [CELL_W-1:0] fill_reg;
    logic [CELL_W-1:0] fill_next;

    logic              is_newline;
    logic              wrap;
    logic              last_row;
    logic [ADDR_W-1:0] cursor_idx;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] wdata;

    assign is_newline = (char_code == NEWLINE_CODE);
    assign last_row   = (row_reg == ROW_W'(SCREEN_HEIGHT - 1));
    assign wrap       = is_newline || (col_reg == COL_W'(SCREEN_WIDTH - 1));
    assign cursor_idx = ADDR_W'(row_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_reg);

    assign stat.fill_busy = (addr_reg != ADDR_W'(CELL_COUNT - 1));
    assign stat.copy_busy = (addr_reg != ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1));
    assign stat.scroll    = wrap && last_row;

    always_comb
    begin
        case (ctrl.addr_op)
            ADDR_ZERO: addr_next = '0;
            ADDR_INC:  addr_next = addr_reg + ADDR_W'(1);
            default:   addr_next = addr_reg;
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (ctrl.cur_op)
            CUR_ADVANCE:
            begin
                if (wrap)
                begin
                    col_next = '0;
                    row_next = last_row ? row_reg : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            CUR_HOME:
            begin
                row_next = '0;
                col_next = '0;
            end
            default:
            begin
                row_next = row_reg;
                col_next = col_reg;
            end
        endcase
    end

    assign fill_next = ctrl.load_fill ? {blank_attr, SPACE_CODE} : fill_reg;

    always_comb
    begin
        we    = 1'b1;
        waddr = addr_reg;
        case (ctrl.wr_sel)
            WR_FILL: wdata = fill_reg;
            WR_COPY: wdata = rdata_reg;
            WR_CHAR:
            begin
                wdata = {bg_color, fg_color, char_code};
                waddr = cursor_idx;
                we    = !is_newline;
            end
            default:
            begin
                wdata = fill_reg;
                we    = 1'b0;
            end
        endcase
    end

    assign raddr = (ctrl.rd_sel == RD_AHEAD) ? addr_next + ADDR_W'(SCREEN_WIDTH)
                                             : ADDR_W'(cell_index);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign cell_data = rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            fill_reg <= {RESET_ATTR, SPACE_CODE};
        end
        else
        begin
            addr_reg <= addr_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            fill_reg <= fill_next;
        end
    end

endmodule
